/* rtl/pgs_pkg.sv */
// Package for the PON grant sizing scheduler: payload and configuration types,
// window mode codes, register indexes and fixed timing constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package pgs_pkg;

   // Fixed link timing in time quanta.
   localparam int unsigned ROUND_TRIP    = 256;
   localparam int unsigned PROCESS_DELAY = 16;
   localparam logic [31:0] ROUND_TRIP_Q  = 32'(ROUND_TRIP);
   localparam logic [31:0] HALF_RT_Q     = 32'(ROUND_TRIP / 2);
   localparam logic [31:0] PROC_DELAY_Q  = 32'(PROCESS_DELAY);

   // Configuration port geometry.
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // Register indexes.
   localparam logic [2:0] REG_INTER_MODE     = 3'd0;
   localparam logic [2:0] REG_DOWNSTREAM_TDM = 3'd1;
   localparam logic [2:0] REG_MAX_WINDOW     = 3'd2;
   localparam logic [2:0] REG_CREDIT_CONST   = 3'd3;
   localparam logic [2:0] REG_CREDIT_FRAC    = 3'd4;
   localparam logic [2:0] REG_CYCLE_LENGTH   = 3'd5;
   localparam logic [2:0] REG_GUARD_TIME     = 3'd6;
   localparam logic [2:0] REG_MPCP_TIME      = 3'd7;

   // Window sizing modes.
   localparam logic [2:0] MODE_FIXED   = 3'd0;
   localparam logic [2:0] MODE_GATED   = 3'd1;
   localparam logic [2:0] MODE_LIMITED = 3'd2;
   localparam logic [2:0] MODE_CONST   = 3'd3;
   localparam logic [2:0] MODE_LINEAR  = 3'd4;
   localparam logic [2:0] MODE_ELASTIC = 3'd5;

   typedef struct packed {
      logic [4:0]  onu_id;
      logic [31:0] now;
      logic [23:0] up_demand;
      logic [23:0] down_demand;
   } req_type;

   typedef struct packed {
      logic [4:0]  grant_onu;
      logic [31:0] grant_start;
      logic [23:0] grant_length;
      logic [31:0] gate_send_time;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  inter_mode;
      logic        downstream_tdm;
      logic [15:0] max_window;
      logic [15:0] credit_const;
      logic [7:0]  credit_frac;
      logic [23:0] cycle_length;
      logic [9:0]  guard_time;
      logic [9:0]  mpcp_time;
   } cfg_type;

endpackage

`default_nettype wire

/* rtl/pgs_csr.sv */
// Configuration register file behind the APB-style port.
// Depends on pgs_pkg for the register indexes and the configuration struct.
`default_nettype none

module pgs_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [pgs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [pgs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [pgs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready,
   output pgs_pkg::cfg_type                     cfg
);
   import pgs_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   // Write decode: each register keeps only its own width of the data.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_INTER_MODE:     cfg_in.inter_mode     = csr_pwdata[2:0];
            REG_DOWNSTREAM_TDM: cfg_in.downstream_tdm = csr_pwdata[0];
            REG_MAX_WINDOW:     cfg_in.max_window     = csr_pwdata[15:0];
            REG_CREDIT_CONST:   cfg_in.credit_const   = csr_pwdata[15:0];
            REG_CREDIT_FRAC:    cfg_in.credit_frac    = csr_pwdata[7:0];
            REG_CYCLE_LENGTH:   cfg_in.cycle_length   = csr_pwdata[23:0];
            REG_GUARD_TIME:     cfg_in.guard_time     = csr_pwdata[9:0];
            REG_MPCP_TIME:      cfg_in.mpcp_time      = csr_pwdata[9:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inter_mode     <= MODE_GATED;
         cfg_ff.downstream_tdm <= 1'b0;
         cfg_ff.max_window     <= 16'd4096;
         cfg_ff.credit_const   <= 16'd0;
         cfg_ff.credit_frac    <= 8'd0;
         cfg_ff.cycle_length   <= 24'd62500;
         cfg_ff.guard_time     <= 10'd64;
         cfg_ff.mpcp_time      <= 10'd32;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux returns the register zero extended.
   always_comb begin
      unique case (reg_idx)
         REG_INTER_MODE:     csr_prdata = 32'(cfg_ff.inter_mode);
         REG_DOWNSTREAM_TDM: csr_prdata = 32'(cfg_ff.downstream_tdm);
         REG_MAX_WINDOW:     csr_prdata = 32'(cfg_ff.max_window);
         REG_CREDIT_CONST:   csr_prdata = 32'(cfg_ff.credit_const);
         REG_CREDIT_FRAC:    csr_prdata = 32'(cfg_ff.credit_frac);
         REG_CYCLE_LENGTH:   csr_prdata = 32'(cfg_ff.cycle_length);
         REG_GUARD_TIME:     csr_prdata = 32'(cfg_ff.guard_time);
         REG_MPCP_TIME:      csr_prdata = 32'(cfg_ff.mpcp_time);
         default:            csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

/* rtl/pgs_window.sv */
// Combinational grant window sizing for the six window modes.
// Depends on pgs_pkg for the mode codes and the configuration struct.
`default_nettype none

module pgs_window (
   input  wire pgs_pkg::cfg_type  cfg,
   input  wire logic [23:0]  up_demand,
   input  wire logic [23:0]  down_demand,
   input  wire logic [23:0]  budget,
   output logic      [23:0]  window
);
   import pgs_pkg::*;

   logic [23:0] demand;
   logic [24:0] max_ext;
   logic [24:0] credit_sum;
   logic [32:0] linear_prod;
   logic [24:0] linear_val;

   // In TDM downstream mode the larger need drives the window.
   assign demand = (cfg.downstream_tdm && (down_demand > up_demand)) ? down_demand
                                                                    : up_demand;

   assign max_ext     = 25'(cfg.max_window);
   assign credit_sum  = 25'(demand) + 25'(cfg.credit_const);
   // Q0.8 scaling by one plus the fraction, truncated.
   assign linear_prod = 33'(demand) * 33'({1'b1, cfg.credit_frac});
   assign linear_val  = linear_prod[32:8];

   always_comb begin
      case (cfg.inter_mode)
         MODE_FIXED:   window = 24'(cfg.max_window);
         MODE_LIMITED: window = (25'(demand) < max_ext) ? demand : 24'(cfg.max_window);
         MODE_CONST:   window = (credit_sum < max_ext) ? credit_sum[23:0]
                                                       : 24'(cfg.max_window);
         MODE_LINEAR:  window = (linear_val < max_ext) ? linear_val[23:0]
                                                       : 24'(cfg.max_window);
         MODE_ELASTIC: window = (demand < budget) ? demand : budget;
         // Gated, and the unused codes, grant the full demand.
         default:      window = demand;
      endcase
   end

endmodule

`default_nettype wire

/* rtl/pon_grant_sizing_scheduler.sv */
// Top level of the PON grant sizing scheduler: input register, grant timing
// and state update, result register. Uses pgs_pkg, pgs_csr and pgs_window.
//
//   channel   ports        transfer moves
//   report    req_*        one ONU report (req_type)
//   grant     rsp_*        one upstream grant (rsp_type)
//   config    csr_*        one register write or read, APB style
//
// A report waits in the input register; its grant is computed from there and
// moves into the result register, so one report can be taken every cycle
// while no stalled grant blocks it. The next free time and cycle budget
// registers close the loop in the compute stage. A stalled grant holds the
// result register and then the input register. Reset is synchronous and
// restores the register defaults and clears both pipeline stages and state.
`default_nettype none

module pon_grant_sizing_scheduler (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire pgs_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output pgs_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [pgs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [pgs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [pgs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import pgs_pkg::*;

   cfg_type     cfg;
   req_type     in_data_ff;
   logic        in_valid_ff, in_valid_in;
   rsp_type     out_data_ff, out_data_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] next_free_ff, next_free_in;
   logic [23:0] budget_ff, budget_in;
   logic        advance, req_accept;
   logic [23:0] budget_now, window;
   logic [31:0] earliest, diff, base, start;
   logic        later;

   pgs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Pipeline flow: the compute stage moves when the result register is free.
   assign advance     = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall   = in_valid_ff & ~advance;
   assign req_accept  = req_valid & ~req_stall;
   assign in_valid_in = req_accept | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & rsp_stall);

   // A report from ONU zero opens a new elastic cycle.
   assign budget_now = (in_data_ff.onu_id == 5'd0) ? cfg.cycle_length : budget_ff;

   pgs_window u_window (
      .cfg         (cfg),
      .up_demand   (in_data_ff.up_demand),
      .down_demand (in_data_ff.down_demand),
      .budget      (budget_now),
      .window      (window)
   );

   // Grant placement with a wrapping "later than" test on the channel time.
   assign earliest = in_data_ff.now + ROUND_TRIP_Q + 32'(cfg.mpcp_time);
   assign diff     = earliest - next_free_ff;
   assign later    = (diff != 32'd0) & ~diff[31];
   assign base     = later ? earliest : next_free_ff;
   assign start    = base - HALF_RT_Q;

   always_comb begin
      next_free_in = next_free_ff;
      budget_in    = budget_ff;
      if (advance) begin
         next_free_in = base + 32'(window) + 32'(cfg.mpcp_time) + 32'(cfg.guard_time);
         budget_in    = (cfg.inter_mode == MODE_ELASTIC) ? (budget_now - window)
                                                         : budget_now;
      end
   end

   always_comb begin
      out_data_in.grant_onu      = in_data_ff.onu_id;
      out_data_in.grant_start    = start;
      out_data_in.grant_length   = window;
      out_data_in.gate_send_time = start - 32'(cfg.mpcp_time) - HALF_RT_Q + PROC_DELAY_Q;
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         next_free_ff <= '0;
         budget_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         next_free_ff <= next_free_in;
         budget_ff    <= budget_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // A report leaving the compute stage shows up as a grant on the next cycle.
   a_advance_to_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_valid && rsp_data.grant_onu == $past(in_data_ff.onu_id)))
      else $error("computed grant did not reach the result register");

   // While the grant is held back the channel state must not move.
   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(next_free_ff) && $stable(budget_ff)))
      else $error("scheduler state changed under a stalled grant");

   // The input register never drops a pending report.
   a_keep_pending: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("pending report lost in the input register");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Testbench for pon_grant_sizing_scheduler: a table of directed reports, then random polling
// rounds under random configurations, each grant checked against a local grant sizing model.
// Depends on pgs_pkg and the scheduler RTL only.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pgs_pkg::*;

   // Mode codes outside the documented range; the block treats them as gated.
   localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
   localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int DRAIN_SLACK     = 8;
   localparam int HOLD_CYCLES     = 300;
   localparam int RANDOM_PHASES   = 14;
   localparam int ITEMS_PER_PHASE = 82;

   typedef struct {
      int      cfg_sel;   // -1 keeps the current settings
      bit      rel;       // now is an offset from the time that ties with the next free time
      req_type rpt;
      bit      typed;
      rsp_type grant;
   } report_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_psel;
   logic             csr_penable;
   logic             csr_pwrite;
   logic [4:0]       csr_paddr;
   logic [31:0]      csr_pwdata;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   // Model state: register copy, next free channel time and elastic budget.
   cfg_type     cfg_now;
   logic [31:0] next_free;
   logic [23:0] budget_left;
   rsp_type     grants_due[$];
   int          mismatch_count;
   bit          calm;
   bit          hold_request;
   logic [31:0] wall;
   int          round_pos;
   int          round_len;

   // Settings used by the directed table.
   cfg_type directed_cfgs [8] = '{
      '{MODE_FIXED,    1'b0, 16'hFFFF, 16'd0,    8'd0,  24'd0,      10'd1023, 10'd1023},
      '{MODE_LIMITED,  1'b1, 16'd1000, 16'd0,    8'd0,  24'd62500,  10'd64,   10'd32},
      '{MODE_CONST,    1'b0, 16'hFFFF, 16'hFFFF, 8'd0,  24'd0,      10'd0,    10'd0},
      '{MODE_LINEAR,   1'b1, 16'hFFFF, 16'd0,    8'hFF, 24'hFFFFFF, 10'd64,   10'd32},
      '{MODE_ELASTIC,  1'b0, 16'd4096, 16'd0,    8'd0,  24'd5000,   10'd64,   10'd32},
      '{MODE_UNUSED_6, 1'b1, 16'd100,  16'd50,   8'd10, 24'd100,    10'd8,    10'd8},
      '{MODE_UNUSED_7, 1'b0, 16'd100,  16'd50,   8'd10, 24'd100,    10'd8,    10'd8},
      '{MODE_FIXED,    1'b0, 16'd0,    16'd0,    8'd0,  24'd0,      10'd0,    10'd0}
   };

   // Directed reports. The first two run on reset settings and have known grants.
   report_row_type directed_plan [23] = '{
      '{-1, 1'b0, '{5'd1, 32'd0, 24'd100, 24'd0}, 1'b1, '{5'd1, 32'd160, 24'd100, 32'd16}},
      '{-1, 1'b0, '{5'd2, 32'd0, 24'd0, 24'd0}, 1'b1, '{5'd2, 32'd356, 24'd0, 32'd212}},
      '{-1, 1'b1, '{5'd3, 32'd0, 24'hFFFFFF, 24'hFFFFFF}, 1'b0, '0},
      '{-1, 1'b1, '{5'd4, 32'h8000_0000, 24'd5, 24'd0}, 1'b0, '0},
      '{-1, 1'b1, '{5'd5, 32'h7FFF_FFFF, 24'd6, 24'd0}, 1'b0, '0},
      '{-1, 1'b1, '{5'd31, 32'hFFFF_FFFF, 24'd7, 24'd0}, 1'b0, '0},
      '{-1, 1'b0, '{5'd31, 32'hFFFF_FFFF, 24'd0, 24'd0}, 1'b0, '0},
      '{0, 1'b0, '{5'd0, 32'd0, 24'd0, 24'd0}, 1'b0, '0},
      '{-1, 1'b0, '{5'd31, 32'hFFFF_FFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b0, '0},
      '{1, 1'b0, '{5'd1, 32'd100, 24'd10, 24'd2000}, 1'b0, '0},
      '{-1, 1'b0, '{5'd2, 32'd200, 24'd500, 24'd20}, 1'b0, '0},
      '{2, 1'b0, '{5'd3, 32'd300, 24'hFFFFFF, 24'd0}, 1'b0, '0},
      '{-1, 1'b0, '{5'd4, 32'd400, 24'd0, 24'd0}, 1'b0, '0},
      '{3, 1'b0, '{5'd5, 32'd500, 24'hFFFFFF, 24'd0}, 1'b0, '0},
      '{-1, 1'b0, '{5'd6, 32'd600, 24'd300, 24'd0}, 1'b0, '0},
      '{-1, 1'b0, '{5'd7, 32'd700, 24'd1, 24'd0}, 1'b0, '0},
      '{4, 1'b0, '{5'd1, 32'd800, 24'd100, 24'd0}, 1'b0, '0},
      '{-1, 1'b0, '{5'd0, 32'd900, 24'd3000, 24'd0}, 1'b0, '0},
      '{-1, 1'b0, '{5'd2, 32'd1000, 24'd3000, 24'd0}, 1'b0, '0},
      '{-1, 1'b0, '{5'd3, 32'd1100, 24'd10, 24'd0}, 1'b0, '0},
      '{5, 1'b0, '{5'd8, 32'd1200, 24'd7, 24'd70000}, 1'b0, '0},
      '{6, 1'b0, '{5'd9, 32'd1300, 24'hABCDEF, 24'd0}, 1'b0, '0},
      '{7, 1'b0, '{5'd10, 32'd1400, 24'd1000, 24'd0}, 1'b0, '0}
   };

   pon_grant_sizing_scheduler uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Caps a window at the largest allowed one.
   function automatic logic [23:0] cap_window(logic [63:0] want);
      return (want < 64'(cfg_now.max_window)) ? 24'(want) : 24'(cfg_now.max_window);
   endfunction

   // Sizes the grant for one report and advances the channel time and budget.
   function automatic rsp_type size_grant(req_type r);
      logic [23:0] demand;
      logic [31:0] earliest;
      logic [31:0] diff;
      logic [23:0] win;
      rsp_type     g;
      if (r.onu_id == 5'd0) begin
         budget_left = cfg_now.cycle_length;
      end
      demand = r.up_demand;
      if (cfg_now.downstream_tdm && r.down_demand > demand) begin
         demand = r.down_demand;
      end
      // The channel moves forward only when the earliest start is later, modulo wrap.
      earliest = r.now + ROUND_TRIP_Q + 32'(cfg_now.mpcp_time);
      diff = earliest - next_free;
      if (diff != 32'd0 && !diff[31]) begin
         next_free = earliest;
      end
      g.grant_onu = r.onu_id;
      g.grant_start = next_free - HALF_RT_Q;
      case (cfg_now.inter_mode)
         MODE_FIXED: win = 24'(cfg_now.max_window);
         MODE_LIMITED: win = cap_window(64'(demand));
         MODE_CONST: win = cap_window(64'(demand) + 64'(cfg_now.credit_const));
         MODE_LINEAR: win = cap_window((64'(demand) * (64'd256 + 64'(cfg_now.credit_frac))) >> 8);
         MODE_ELASTIC: begin
            win = (demand < budget_left) ? demand : budget_left;
            budget_left = budget_left - win;
         end
         default: win = demand;
      endcase
      next_free = next_free + 32'(win) + 32'(cfg_now.mpcp_time) + 32'(cfg_now.guard_time);
      g.grant_length = win;
      g.gate_send_time = g.grant_start - 32'(cfg_now.mpcp_time) - HALF_RT_Q + PROC_DELAY_Q;
      return g;
   endfunction

   // Register value as the port returns it, zero extended.
   function automatic logic [31:0] field_of(cfg_type c, logic [2:0] idx);
      case (idx)
         REG_INTER_MODE:     return 32'(c.inter_mode);
         REG_DOWNSTREAM_TDM: return 32'(c.downstream_tdm);
         REG_MAX_WINDOW:     return 32'(c.max_window);
         REG_CREDIT_CONST:   return 32'(c.credit_const);
         REG_CREDIT_FRAC:    return 32'(c.credit_frac);
         REG_CYCLE_LENGTH:   return 32'(c.cycle_length);
         REG_GUARD_TIME:     return 32'(c.guard_time);
         default:            return 32'(c.mpcp_time);
      endcase
   endfunction

   // Mirrors one register write into the model's copy; upper bits are dropped.
   task automatic store_field(input logic [2:0] idx, input logic [31:0] value);
      case (idx)
         REG_INTER_MODE:     cfg_now.inter_mode = value[2:0];
         REG_DOWNSTREAM_TDM: cfg_now.downstream_tdm = value[0];
         REG_MAX_WINDOW:     cfg_now.max_window = value[15:0];
         REG_CREDIT_CONST:   cfg_now.credit_const = value[15:0];
         REG_CREDIT_FRAC:    cfg_now.credit_frac = value[7:0];
         REG_CYCLE_LENGTH:   cfg_now.cycle_length = value[23:0];
         REG_GUARD_TIME:     cfg_now.guard_time = value[9:0];
         default:            cfg_now.mpcp_time = value[9:0];
      endcase
   endtask

   // One configuration transfer: setup phase, then access until pready.
   task automatic csr_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = wr;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Writes every register, sometimes with junk above the field, then reads all back.
   task automatic apply_config(input cfg_type c);
      logic [31:0] value;
      logic [31:0] junk;
      logic [31:0] readback;
      for (int i = 0; i < 8; i++) begin
         value = field_of(c, 3'(i));
         junk = $urandom_range(0, 1) ? ($urandom & ~field_of(cfg_type'('1), 3'(i))) : 32'd0;
         csr_access(1'b1, 3'(i), value | junk, readback);
         store_field(3'(i), value | junk);
      end
      for (int i = 0; i < 8; i++) begin
         csr_access(1'b0, 3'(i), 32'd0, readback);
         if (readback !== field_of(cfg_now, 3'(i))) begin
            $error("register %0d: expected %h, got %h", i, field_of(cfg_now, 3'(i)), readback);
            mismatch_count++;
         end
      end
   endtask

   // Offers one report and records its grant once the transfer happens.
   task automatic send_report(input req_type r, input bit typed, input rsp_type typed_grant);
      rsp_type predicted;
      @(negedge clock);
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = size_grant(r);
      grants_due = {grants_due, (typed ? typed_grant : predicted)};
   endtask

   // Random gap on the report side: mostly none or short, now and then long.
   task automatic sender_gap();
      int n;
      n = 0;
      if (!calm) begin
         case ($urandom_range(0, 19))
            0: n = $urandom_range(20, 40);
            1, 2, 3, 4, 5, 6: n = $urandom_range(1, 3);
            default: n = 0;
         endcase
      end
      if (n > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         req_data = $bits(req_type)'({$urandom, $urandom, $urandom});
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Stops offering reports and waits until every grant is back.
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (grants_due.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // Compares one grant transfer with the oldest expected grant.
   task automatic take_grant(input rsp_type got);
      rsp_type want;
      if (grants_due.size() == 0) begin
         $error("grant for ONU %0d arrived with none expected", got.grant_onu);
         mismatch_count++;
         return;
      end
      want = grants_due.pop_front();
      if (got.grant_onu !== want.grant_onu) begin
         $error("grant_onu: expected %0d, got %0d", want.grant_onu, got.grant_onu);
         mismatch_count++;
      end
      if (got.grant_start !== want.grant_start) begin
         $error("grant_start: expected %h, got %h", want.grant_start, got.grant_start);
         mismatch_count++;
      end
      if (got.grant_length !== want.grant_length) begin
         $error("grant_length: expected %h, got %h", want.grant_length, got.grant_length);
         mismatch_count++;
      end
      if (got.gate_send_time !== want.gate_send_time) begin
         $error("gate_send_time: expected %h, got %h", want.gate_send_time, got.gate_send_time);
         mismatch_count++;
      end
   endtask

   // Demand: mostly modest, sometimes any 24-bit value or the maximum.
   function automatic logic [23:0] random_demand();
      case ($urandom_range(0, 9))
         0: return 24'($urandom);
         1: return 24'hFFFFFF;
         default: return 24'($urandom_range(0, 4000));
      endcase
   endfunction

   // Mostly ordered polling rounds starting at ONU 0, with stray reports mixed in.
   function automatic req_type random_report();
      req_type r;
      if ($urandom_range(0, 4) != 0) begin
         r.onu_id = 5'(round_pos);
         round_pos++;
         if (round_pos >= round_len) begin
            round_pos = 0;
            round_len = $urandom_range(1, 32);
         end
      end else begin
         r.onu_id = 5'($urandom);
      end
      case ($urandom_range(0, 3))
         0, 1: begin
            wall = wall + 32'($urandom_range(0, 3000));
            r.now = wall;
         end
         2: r.now = next_free - ROUND_TRIP_Q - 32'(cfg_now.mpcp_time)
                    + 32'($urandom_range(0, 64)) - 32'd32;
         default: r.now = $urandom;
      endcase
      r.up_demand = random_demand();
      r.down_demand = random_demand();
      return r;
   endfunction

   // Settings of one random phase: all minimum, all maximum, then random per mode.
   function automatic cfg_type phase_config(int ph);
      cfg_type c;
      c = $bits(cfg_type)'({$urandom, $urandom, $urandom});
      c.inter_mode = 3'(ph % 8);
      if ($urandom_range(0, 1)) begin
         c.max_window = 16'($urandom_range(0, 3000));
      end
      if ($urandom_range(0, 1)) begin
         c.cycle_length = 24'($urandom_range(0, 20000));
      end
      if (ph == 0) begin
         c = '0;
      end else if (ph == 1) begin
         c = '1;
      end
      return c;
   endfunction

   // Grant side: checks each transfer and stalls at random, or for a long hold when asked.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            take_grant(rsp_data);
         end
         @(negedge clock);
         if (hold_request) begin
            stall_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else if (calm) begin
            rsp_stall = 1'b0;
         end else begin
            case ($urandom_range(0, 19))
               0: stall_left = $urandom_range(15, 50);
               1, 2, 3: stall_left = $urandom_range(1, 3);
               default: stall_left = 0;
            endcase
            rsp_stall = (stall_left != 0);
            if (stall_left != 0) begin
               stall_left--;
            end
         end
      end
   end

   // Run limit.
   initial begin
      int cycle_count;
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) break;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Main sequence: reset, directed table, random phases, drain and verdict.
   initial begin
      req_type rpt;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      calm = 1'b0;
      hold_request = 1'b0;
      mismatch_count = 0;
      cfg_now = '{MODE_GATED, 1'b0, 16'd4096, 16'd0, 8'd0, 24'd62500, 10'd64, 10'd32};
      next_free = '0;
      budget_left = '0;
      round_pos = 0;
      round_len = 8;
      wall = $urandom;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed reports; settings change only once the block has drained.
      foreach (directed_plan[k]) begin
         if (directed_plan[k].cfg_sel >= 0) begin
            wait_idle();
            apply_config(directed_cfgs[directed_plan[k].cfg_sel]);
         end
         rpt = directed_plan[k].rpt;
         if (directed_plan[k].rel) begin
            rpt.now = next_free - ROUND_TRIP_Q - 32'(cfg_now.mpcp_time) + rpt.now;
         end
         send_report(rpt, directed_plan[k].typed, directed_plan[k].grant);
         sender_gap();
      end

      // Random phases. Phase 3 opens with a long hold on the grant side while
      // reports keep coming; phase 6 pauses mid-way until every grant is back.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         apply_config(phase_config(ph));
         if (ph == 3) begin
            hold_request = 1'b1;
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            calm = ((ph % 2 == 0) && n < 16) || (ph == 3 && n < 30);
            if (ph == 6 && n == 40) begin
               wait_idle();
            end
            send_report(random_report(), 1'b0, '0);
            sender_gap();
         end
         calm = 1'b0;
      end

      wait_idle();
      if (mismatch_count == 0 && grants_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/pgs_pkg.sv
rtl/pgs_csr.sv
rtl/pgs_window.sv
rtl/pon_grant_sizing_scheduler.sv
bench/testbench.sv
